// ===== rtl/pew_pkg.sv =====
// pew_pkg: shared types, constants and the rounding helper
// used by the weight engine, its multiplier and its divider
package pew_pkg;

    localparam int W_COORD  = 32;
    localparam int W_DIFF   = 33;
    localparam int W_WEIGHT = 48;
    localparam int W_PROD   = 96;
    localparam int W_ACC    = 100;
    localparam int W_NUM    = 64;

    localparam logic signed [W_WEIGHT-1:0] ONE_Q24 = 48'sd16777216;
    localparam logic signed [W_WEIGHT-1:0] ONE_Q16 = 48'sd65536;
    localparam logic [W_WEIGHT-1:0] POS48 = 48'h7FFF_FFFF_FFFF;
    localparam logic [W_WEIGHT-1:0] NEG48 = 48'h8000_0000_0000;

    typedef struct packed {
        logic                       start;
        logic signed [W_WEIGHT-1:0] a;
        logic signed [W_WEIGHT-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [W_PROD-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic                       start;
        logic signed [W_WEIGHT-1:0] num;
        logic signed [W_DIFF-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [W_WEIGHT-1:0] quot;
    } t_div_rsp;

    // round half up by 16 fraction bits, saturate to 48 bits; msb is the clip flag
    function automatic logic [W_WEIGHT:0] round_sat(input logic signed [W_ACC-1:0] a);
        logic signed [W_ACC-1:0] s;
        logic signed [W_ACC-1:0] t;
        logic [W_WEIGHT:0]       r;
        s = a + W_ACC'(32768);
        t = s >>> 16;
        if ((&t[W_ACC-1:W_WEIGHT-1]) || !(|t[W_ACC-1:W_WEIGHT-1])) begin
            r = {1'b0, t[W_WEIGHT-1:0]};
        end else if (t[W_ACC-1]) begin
            r = {1'b1, NEG48};
        end else begin
            r = {1'b1, POS48};
        end
        return r;
    endfunction

endpackage

// ===== rtl/pew_mul.sv =====
// pew_mul: signed 48 x 48 multiplier, one 48 x 16 partial product a cycle
// depends on pew_pkg
module pew_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pew_pkg::t_mul_req i_req,
    output pew_pkg::t_mul_rsp o_rsp
);
    import pew_pkg::*;

    logic [W_WEIGHT-1:0] r_a;
    logic [W_WEIGHT-1:0] r_b;
    logic                r_neg;
    logic [1:0]          r_i;
    logic                r_busy;
    logic                r_done;
    logic [W_PROD-1:0]   r_p;
    logic [15:0]         s_chunk;
    logic [63:0]         s_pp;
    logic [W_PROD-1:0]   s_sh;

    always_comb begin
        case (r_i)
            2'd0:    s_chunk = r_b[15:0];
            2'd1:    s_chunk = r_b[31:16];
            default: s_chunk = r_b[47:32];
        endcase
        s_pp = r_a * s_chunk;
        case (r_i)
            2'd0:    s_sh = {32'b0, s_pp};
            2'd1:    s_sh = {16'b0, s_pp, 16'b0};
            default: s_sh = {s_pp, 32'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a[W_WEIGHT-1] ? W_WEIGHT'(-i_req.a) : i_req.a;
                r_b    <= i_req.b[W_WEIGHT-1] ? W_WEIGHT'(-i_req.b) : i_req.b;
                r_neg  <= i_req.a[W_WEIGHT-1] ^ i_req.b[W_WEIGHT-1];
                r_p    <= '0;
                r_i    <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p <= r_p + s_sh;
                r_i <= r_i + 2'd1;
                if (r_i == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_neg ? W_PROD'(-r_p) : r_p;

endmodule

// ===== rtl/pew_div.sv =====
// pew_div: restoring divider, q24.24 by q16.16, one quotient bit a cycle
// rounds half away from zero and saturates; depends on pew_pkg
module pew_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pew_pkg::t_div_req i_req,
    output pew_pkg::t_div_rsp o_rsp
);
    import pew_pkg::*;

    logic [W_NUM-1:0]    r_n;
    logic [W_DIFF-1:0]   r_den;
    logic [W_DIFF-1:0]   r_rem;
    logic                r_neg;
    logic [5:0]          r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [W_DIFF:0]     s_rem2;
    logic [W_DIFF:0]     s_sub;
    logic [W_WEIGHT-1:0] s_mag;
    logic [W_DIFF-1:0]   s_dmag;

    assign s_mag  = i_req.num[W_WEIGHT-1] ? W_WEIGHT'(-i_req.num) : i_req.num;
    assign s_dmag = i_req.den[W_DIFF-1] ? W_DIFF'(-i_req.den) : i_req.den;
    assign s_rem2 = {r_rem, r_n[W_NUM-1]};
    assign s_sub  = s_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_n    <= {s_mag, 16'b0} + W_NUM'(s_dmag >> 1);
                r_den  <= s_dmag;
                r_rem  <= '0;
                r_neg  <= i_req.num[W_WEIGHT-1] ^ i_req.den[W_DIFF-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!s_sub[W_DIFF]) begin
                    r_rem <= s_sub[W_DIFF-1:0];
                    r_n   <= {r_n[W_NUM-2:0], 1'b1};
                end else begin
                    r_rem <= s_rem2[W_DIFF-1:0];
                    r_n   <= {r_n[W_NUM-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_neg) begin
            if (r_n > W_NUM'(NEG48)) o_rsp.quot = NEG48;
            else                     o_rsp.quot = W_WEIGHT'(-r_n[W_WEIGHT-1:0]);
        end else begin
            if (r_n > W_NUM'(POS48)) o_rsp.quot = POS48;
            else                     o_rsp.quot = r_n[W_WEIGHT-1:0];
        end
    end

endmodule

// ===== rtl/polynomial_extrapolation_weights.sv =====
// polynomial_extrapolation_weights: lagrange weights in newton form, top level
// depends on pew_pkg, pew_mul and pew_div
//
// Load support points with tuser 0 (slot in tdata[2:0], q16.16 abscissa in
// tdata[34:3]). Send a target with tuser 1 and the block answers with one
// q24.24 weight per support point, index 0 first, tlast on index n-1, where n
// is support_count clamped to 1..MAX_POINTS. The first target after a load or
// a count write rebuilds the reciprocal table: n(n+1)/2 entries, each made of
// up to n-1 divisions on the shared bit-serial divider, n(n-1)(n+1)/3
// divisions in all. A target then computes the basis products and the
// n(n+1)/2 multiply-accumulates on the shared multiplier. The input is taken
// only while the engine is idle; the finished weight sits in an output
// register, so the next target is accepted while the last weight still
// waits. Support points and the table live in synchronous memories with
// registered read data.
module polynomial_extrapolation_weights #(
    parameter int MAX_POINTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // point_index[2:0], coordinate[34:3], zero pad
    input  logic        s_tuser,   // mode
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // weight[47:0], weight_index[50:48], zero pad
    output logic [1:0]  m_tuser,   // degenerate[0], saturated[1]
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pew_pkg::*;

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int TD = 1 << (2 * IW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_B_RDW  = 4'd1;
    localparam logic [3:0] S_B_WW   = 4'd2;
    localparam logic [3:0] S_B_RDU  = 4'd3;
    localparam logic [3:0] S_B_GOTU = 4'd4;
    localparam logic [3:0] S_B_DIV  = 4'd5;
    localparam logic [3:0] S_B_WR   = 4'd6;
    localparam logic [3:0] S_P_INIT = 4'd7;
    localparam logic [3:0] S_P_GOT  = 4'd8;
    localparam logic [3:0] S_P_MUL  = 4'd9;
    localparam logic [3:0] S_W_JST  = 4'd10;
    localparam logic [3:0] S_W_RD   = 4'd11;
    localparam logic [3:0] S_W_GOT  = 4'd12;
    localparam logic [3:0] S_W_MUL  = 4'd13;
    localparam logic [3:0] S_W_OUT  = 4'd14;

    // memories: support points and reciprocal table
    logic [W_COORD-1:0]  r_sp_mem [MAX_POINTS];
    logic [W_WEIGHT-1:0] r_tb_mem [TD];
    logic [W_COORD-1:0]  r_sp_q;
    logic [W_WEIGHT-1:0] r_tb_q;

    // basis products, one read place per cycle
    logic signed [W_WEIGHT-1:0] r_basis [MAX_POINTS];

    logic [3:0]                 r_state;
    logic [3:0]                 r_cnt;
    logic                       r_tvalid;
    logic                       r_deg;
    logic                       r_bclip;
    logic signed [W_COORD-1:0]  r_x;
    logic signed [W_COORD-1:0]  r_xw;
    logic signed [W_WEIGHT-1:0] r_r;
    logic [IW-1:0]              r_t;
    logic [IW-1:0]              r_w;
    logic [CW-1:0]              r_u;
    logic [CW-1:0]              r_k;
    logic [IW-1:0]              r_j;
    logic signed [W_ACC-1:0]    r_acc;

    logic                       r_ovalid;
    logic [W_WEIGHT-1:0]        r_oweight;
    logic [IW-1:0]              r_oidx;
    logic                       r_olast;
    logic                       r_odeg;
    logic                       r_osat;

    logic [CW-1:0]              s_n;
    logic [IW-1:0]              s_sp_addr;
    logic [2*IW-1:0]            s_tb_addr;
    logic [IW-1:0]              s_bidx;
    logic signed [W_WEIGHT-1:0] s_bq;
    logic signed [W_DIFF-1:0]   s_dw;
    logic signed [W_DIFF-1:0]   s_dx;
    logic [W_WEIGHT:0]          s_rb;
    logic [W_WEIGHT:0]          s_rw;
    logic                       s_in_acc;
    logic                       s_out_free;
    logic                       s_cfg_wr;
    t_mul_req                   s_mreq;
    t_mul_rsp                   s_mrsp;
    t_div_req                   s_dreq;
    t_div_rsp                   s_drsp;

    pew_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(s_mreq), .o_rsp(s_mrsp));
    pew_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(s_dreq), .o_rsp(s_drsp));

    // active point count
    always_comb begin
        if (r_cnt == 4'd0)                   s_n = CW'(1);
        else if (int'(r_cnt) > MAX_POINTS)   s_n = CW'(MAX_POINTS);
        else                                 s_n = CW'(r_cnt);
    end

    // support memory read address
    always_comb begin
        case (r_state)
            S_B_RDW: s_sp_addr = r_w;
            S_B_RDU: s_sp_addr = r_u[IW-1:0];
            S_P_MUL: s_sp_addr = r_k[IW-1:0];
            default: s_sp_addr = '0;
        endcase
    end

    assign s_tb_addr = {r_k[IW-1:0], r_j};
    assign s_bidx    = (r_state == S_P_GOT) ? IW'(r_k - CW'(1)) : r_k[IW-1:0];
    assign s_bq      = r_basis[s_bidx];

    // differences against the support point just read
    assign s_dw = {r_xw[W_COORD-1], r_xw} - {r_sp_q[W_COORD-1], r_sp_q};
    assign s_dx = {r_x[W_COORD-1], r_x} - {r_sp_q[W_COORD-1], r_sp_q};

    assign s_rb = round_sat({{(W_ACC-W_PROD){s_mrsp.prod[W_PROD-1]}}, s_mrsp.prod});
    assign s_rw = round_sat(r_acc);

    always_comb begin
        s_mreq.start = (r_state == S_P_GOT) || (r_state == S_W_GOT);
        s_mreq.a     = s_bq;
        s_mreq.b     = (r_state == S_P_GOT)
                     ? {{(W_WEIGHT-W_DIFF){s_dx[W_DIFF-1]}}, s_dx}
                     : r_tb_q;
        s_dreq.start = (r_state == S_B_GOTU) && (s_dw != '0);
        s_dreq.num   = r_r;
        s_dreq.den   = s_dw;
    end

    assign s_tready   = (r_state == S_IDLE);
    assign s_in_acc   = s_tvalid && s_tready;
    assign s_out_free = !r_ovalid || m_tready;
    assign pready     = 1'b1;
    assign s_cfg_wr   = psel && penable && pwrite && !paddr[2];
    assign prdata     = paddr[2] ? 32'd0 : {28'd0, r_cnt};

    // memories
    always_ff @(posedge i_clk) begin
        if (s_in_acc && !s_tuser && (int'(s_tdata[2:0]) < MAX_POINTS)) begin
            r_sp_mem[IW'(s_tdata[2:0])] <= s_tdata[34:3];
        end
        r_sp_q <= r_sp_mem[s_sp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_B_WR) begin
            r_tb_mem[{r_t, r_w}] <= r_r;
        end
        r_tb_q <= r_tb_mem[s_tb_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 4'd1;
            r_tvalid <= 1'b0;
            r_deg    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // the output stage refills it directly when a weight is ready
            if (r_ovalid && m_tready && (r_state != S_W_OUT)) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_in_acc) begin
                        r_x <= s_tdata[34:3];
                        if (!s_tuser) begin
                            if (int'(s_tdata[2:0]) < MAX_POINTS) r_tvalid <= 1'b0;
                        end else if (!r_tvalid) begin
                            r_t     <= '0;
                            r_w     <= '0;
                            r_deg   <= 1'b0;
                            r_state <= S_B_RDW;
                        end else begin
                            r_state <= S_P_INIT;
                        end
                    end
                end
                S_B_RDW: r_state <= S_B_WW;
                S_B_WW: begin
                    r_xw    <= r_sp_q;
                    r_u     <= '0;
                    r_r     <= ONE_Q24;
                    r_state <= S_B_RDU;
                end
                S_B_RDU: begin
                    if (r_u > CW'(r_t)) r_state <= S_B_WR;
                    else if (r_u == CW'(r_w)) r_u <= r_u + CW'(1);
                    else r_state <= S_B_GOTU;
                end
                S_B_GOTU: begin
                    if (s_dw == '0) begin
                        // coinciding points: entry forced to zero
                        r_r     <= '0;
                        r_deg   <= 1'b1;
                        r_state <= S_B_WR;
                    end else begin
                        r_state <= S_B_DIV;
                    end
                end
                S_B_DIV: begin
                    if (s_drsp.done) begin
                        r_r     <= s_drsp.quot;
                        r_u     <= r_u + CW'(1);
                        r_state <= S_B_RDU;
                    end
                end
                S_B_WR: begin
                    if (r_w < r_t) begin
                        r_w     <= r_w + IW'(1);
                        r_state <= S_B_RDW;
                    end else if ((CW'(r_t) + CW'(1)) < s_n) begin
                        r_t     <= r_t + IW'(1);
                        r_w     <= '0;
                        r_state <= S_B_RDW;
                    end else begin
                        r_tvalid <= 1'b1;
                        r_state  <= S_P_INIT;
                    end
                end
                S_P_INIT: begin
                    r_basis[0] <= ONE_Q16;
                    r_bclip    <= 1'b0;
                    r_k        <= CW'(1);
                    r_j        <= '0;
                    if (s_n == CW'(1)) r_state <= S_W_JST;
                    else               r_state <= S_P_GOT;
                end
                S_P_GOT: r_state <= S_P_MUL;
                S_P_MUL: begin
                    if (s_mrsp.done) begin
                        r_basis[r_k[IW-1:0]] <= s_rb[W_WEIGHT-1:0];
                        r_bclip <= r_bclip | s_rb[W_WEIGHT];
                        r_k     <= r_k + CW'(1);
                        if ((r_k + CW'(1)) < s_n) r_state <= S_P_GOT;
                        else                     r_state <= S_W_JST;
                    end
                end
                S_W_JST: begin
                    r_acc   <= '0;
                    r_k     <= CW'(r_j);
                    r_state <= S_W_RD;
                end
                S_W_RD:  r_state <= S_W_GOT;
                S_W_GOT: r_state <= S_W_MUL;
                S_W_MUL: begin
                    if (s_mrsp.done) begin
                        r_acc <= r_acc
                               + {{(W_ACC-W_PROD){s_mrsp.prod[W_PROD-1]}}, s_mrsp.prod};
                        if ((r_k + CW'(1)) < s_n) begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_W_RD;
                        end else begin
                            r_state <= S_W_OUT;
                        end
                    end
                end
                S_W_OUT: begin
                    if (s_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_oweight <= s_rw[W_WEIGHT-1:0];
                        r_oidx    <= r_j;
                        r_olast   <= (CW'(r_j) + CW'(1)) == s_n;
                        r_odeg    <= r_deg;
                        r_osat    <= s_rw[W_WEIGHT] | r_bclip;
                        if ((CW'(r_j) + CW'(1)) < s_n) begin
                            r_j     <= r_j + IW'(1);
                            r_state <= S_W_JST;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (s_cfg_wr) begin
                r_cnt    <= pwdata[3:0];
                r_tvalid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {5'd0, 3'(r_oidx), r_oweight};
    assign m_tuser  = {r_osat, r_odeg};
    assign m_tlast  = r_olast;

endmodule

// ===== rtl/pew_chk.sv =====
// pew_chk: port-level checks for polynomial_extrapolation_weights
// bound to the top level; no package needed
module pew_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    logic [2:0] r_exp;
    logic [3:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= 3'd0;
            r_cnt <= 4'd1;
        end else begin
            if (m_tvalid && m_tready) r_exp <= m_tlast ? 3'd0 : r_exp + 3'd1;
            if (psel && penable && pwrite && !paddr[2]) r_cnt <= pwdata[3:0];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped while stalled");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[50:48] == r_exp)
        else $error("weight index out of order");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && !pwrite && !paddr[2] |-> prdata == {28'd0, r_cnt})
        else $error("register read mismatch");

endmodule

bind polynomial_extrapolation_weights pew_chk u_pew_chk (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for polynomial_extrapolation_weights
// depends on pew_pkg and the rtl top level; drives the stream and apb ports
module tb;
    import pew_pkg::*;

    localparam int NPTS      = 8;
    localparam int WD_LIMIT  = 200000;  // must outlast a table rebuild at n = 8
    localparam int HOLD_LEN  = 2000;    // long receiver hold-off
    localparam int TAIL_WAIT = 300;
    localparam logic [2:0] ADDR_COUNT  = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam logic       MODE_LOAD   = 1'b0;
    localparam logic       MODE_TARGET = 1'b1;
    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000_0000;

    typedef struct {
        logic              mode;
        logic [2:0]        slot;
        logic signed [31:0] coord;
    } t_item;

    typedef struct {
        logic [47:0] weight;
        logic [2:0]  index;
        logic        last;
        logic        degen;
        logic        sat;
    } t_weight;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    polynomial_extrapolation_weights #(.MAX_POINTS(NPTS)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // weight predictor: own copy of points, reciprocal table and count
    // ---------------------------------------------------------------
    logic signed [63:0] pt_store [NPTS];
    logic signed [63:0] recip [NPTS][NPTS];
    bit                 recip_ok = 0;
    bit                 coincide = 0;
    logic [3:0]         pt_count = 4'd1;

    t_weight weights_due [$];
    t_item   pending [$];

    int n_loads = 0, n_targets = 0, n_weights = 0, n_sat = 0, n_degen = 0;
    int n_errors = 0;

    // round half up by 16 fraction bits, clip to 48 bits signed
    function automatic logic signed [63:0] round_clip(input logic signed [127:0] a,
                                                      inout bit clip);
        logic signed [127:0] s;
        s = (a + 128'sd32768) >>> 16;
        if (s > SAT_HI) begin
            clip = 1;
            return SAT_HI[63:0];
        end
        if (s < SAT_LO) begin
            clip = 1;
            return SAT_LO[63:0];
        end
        return s[63:0];
    endfunction

    // q24.24 over q16.16, round half away from zero, clipped to 48 bits
    function automatic logic signed [63:0] recip_div(input logic signed [63:0] r,
                                                     input logic signed [63:0] d);
        logic [63:0] num, den, q;
        num = (r < 0 ? -r : r) << 16;
        den = d < 0 ? -d : d;
        q = (num + den / 2) / den;
        if ((r < 0) != (d < 0)) begin
            if (q > {16'd0, NEG48}) q = {16'd0, NEG48};
            return -$signed(q);
        end
        if (q > {16'd0, POS48}) q = {16'd0, POS48};
        return $signed(q);
    endfunction

    function automatic int points_in_use();
        if (pt_count < 1) return 1;
        if (pt_count > NPTS) return NPTS;
        return int'(pt_count);
    endfunction

    task automatic rebuild_recip(input int n);
        logic signed [63:0] r, d;
        coincide = 0;
        for (int t = 0; t < n; t++)
            for (int w = 0; w < t; w++)
                if (pt_store[t] == pt_store[w]) coincide = 1;
        for (int t = 0; t < NPTS; t++)
            for (int w = 0; w < NPTS; w++) recip[t][w] = '0;
        for (int t = 0; t < n; t++) begin
            for (int w = 0; w <= t; w++) begin
                r = 64'(ONE_Q24);
                for (int u = 0; u <= t; u++) begin
                    if (u != w && r != 0) begin
                        d = pt_store[w] - pt_store[u];
                        // a zero difference zeroes the whole entry
                        if (d == 0) r = 0;
                        else r = recip_div(r, d);
                    end
                end
                recip[t][w] = r;
            end
        end
        recip_ok = 1;
    endtask

    task automatic predict_word(input t_item it);
        logic signed [63:0]  basis [NPTS];
        logic signed [127:0] acc, pa, pb;
        bit                  basis_clip, clip;
        int                  n;
        t_weight             e;
        basis_clip = 0;
        if (it.mode == MODE_LOAD) begin
            pt_store[it.slot] = 64'(it.coord);
            recip_ok = 0;
            n_loads++;
            return;
        end
        n_targets++;
        n = points_in_use();
        if (!recip_ok) rebuild_recip(n);
        basis[0] = 64'(ONE_Q16);
        for (int k = 1; k < n; k++) begin
            pa = 128'(basis[k-1]);
            pb = 128'(64'(it.coord) - pt_store[k-1]);
            basis[k] = round_clip(pa * pb, basis_clip);
        end
        for (int j = 0; j < n; j++) begin
            acc = '0;
            clip = basis_clip;
            for (int k = j; k < n; k++) begin
                pa = 128'(basis[k]);
                pb = 128'(recip[k][j]);
                acc = acc + pa * pb;
            end
            e.weight = 48'(round_clip(acc, clip));
            e.index  = 3'(j);
            e.last   = (j == n - 1);
            e.degen  = coincide;
            e.sat    = clip;
            weights_due.push_back(e);
        end
    endtask

    // ---------------------------------------------------------------
    // input driver and input-side acceptance
    // ---------------------------------------------------------------
    t_item cur_word;
    bit    word_taken = 0;
    bit    quiet = 0;      // no idling in the closing part
    int    send_gap = 0;
    int    accepts = 0;

    always @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            word_taken = 1;
            accepts++;
            predict_word(cur_word);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || word_taken)) begin
            word_taken = 0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                cur_word = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, cur_word.coord, cur_word.slot};
                s_tuser  <= cur_word.mode;
                if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall bursts plus one long hold-off
    // ---------------------------------------------------------------
    bit hold_req = 0;
    int hold_left = 0;
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_LEN;
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // output checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_weight e;
        if (m_tvalid && m_tready) begin
            accepts++;
            n_weights++;
            if (weights_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected weight word: weight %h index %0d", m_tdata[47:0],
                             m_tdata[50:48]);
            end else begin
                e = weights_due.pop_front();
                if (e.sat) n_sat++;
                if (e.degen) n_degen++;
                if (m_tdata[47:0] !== e.weight || m_tdata[50:48] !== e.index ||
                    m_tdata[55:51] !== 5'd0 || m_tlast !== e.last ||
                    m_tuser[0] !== e.degen || m_tuser[1] !== e.sat) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("weight mismatch: exp w %h i %0d l %b d %b s %b, got w %h i %0d l %b d %b s %b",
                                 e.weight, e.index, e.last, e.degen, e.sat,
                                 m_tdata[47:0], m_tdata[50:48], m_tlast, m_tuser[0],
                                 m_tuser[1]);
                end
            end
        end
    end

    // watchdog: cycles with no word accepted on either side
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (accepts != 0) idle_cycles = 0;
        else idle_cycles++;
        accepts = 0;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    logic signed [31:0] gen_pts [NPTS];   // points as queued, for near-point targets

    task automatic queue_load(input logic [2:0] slot, input logic signed [31:0] c);
        t_item it;
        it.mode = MODE_LOAD;
        it.slot = slot;
        it.coord = c;
        gen_pts[slot] = c;
        pending.push_back(it);
    endtask

    task automatic queue_target(input logic signed [31:0] c);
        t_item it;
        it.mode = MODE_TARGET;
        it.slot = 3'($urandom);   // ignored by the block
        it.coord = c;
        pending.push_back(it);
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1, 2: return $signed($urandom_range(0, 1048575)) - 32'sd524288;
            default: return gen_pts[$urandom_range(0, NPTS-1)] +
                            ($signed($urandom_range(0, 255)) - 32'sd128);
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_COUNT) begin
            pt_count = data[3:0];
            recip_ok = 0;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // sender pause: everything sent, every weight back, then a settling gap
    task automatic drain();
        while (pending.size() > 0 || s_tvalid || weights_due.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    int phase_count [10] = '{3, 0, 2, 15, 5, 1, 7, 6, 2, 4};
    int phase_items [10] = '{60, 30, 60, 25, 50, 30, 30, 40, 40, 60};

    initial begin
        int load_pct;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every slot loaded first, so no unwritten point is ever read
        apb_write(ADDR_COUNT, 32'd4);
        for (int s = 0; s < NPTS; s++) queue_load(3'(s), 32'sh0001_0000 * s - 32'sh0002_0000);
        queue_target(32'sh0000_0000);
        queue_target(32'sh7FFF_FFFF);          // extreme targets clip the basis products
        queue_target(32'sh8000_0000);
        queue_target(32'sh0000_8000);          // half way between two points
        queue_target(gen_pts[2]);              // exactly on a support point
        queue_load(3'd1, 32'sh8000_0000);      // extreme support abscissa
        queue_load(3'd3, 32'sh7FFF_FFFF);
        queue_target(32'sh0000_0001);
        queue_load(3'd2, 32'sh0000_0001);      // nearly coinciding: tiny differences
        queue_load(3'd3, 32'sh0000_0002);
        queue_target(32'sh0040_0000);
        queue_load(3'd1, 32'sh0000_0000);      // coinciding with slot 0 -> degenerate
        queue_load(3'd0, 32'sh0000_0000);
        queue_target(32'sh0001_0000);
        queue_load(3'd1, 32'sh0001_0000);
        queue_target(32'shFFFF_0000);
        drain();

        apb_write(ADDR_COUNT, 32'd8);
        queue_target(32'sh0003_8000);
        queue_target(32'shFFF0_0000);
        drain();

        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);  // no such register: ignored
        queue_target(32'sh0000_4000);
        drain();

        // random phases over several point counts, including out of range ones
        for (int p = 0; p < 10; p++) begin
            apb_write(ADDR_COUNT, 32'(phase_count[p]));
            if (p == 2) hold_req = 1;   // fast count: the block backs up under the hold
            if (p == 9) quiet = 1;
            load_pct = (phase_count[p] >= 7) ? 4 : 15;
            for (int i = 0; i < phase_items[p]; i++) begin
                if ($urandom_range(0, 99) < load_pct) begin
                    if ($urandom_range(0, 19) == 0)
                        queue_load(3'($urandom), gen_pts[$urandom_range(0, NPTS-1)]);
                    else
                        queue_load(3'($urandom), pick_coord());
                end else begin
                    queue_target(pick_coord());
                end
            end
            drain();
        end

        $display("covered %0d loads and %0d targets, %0d weights checked",
                 n_loads, n_targets, n_weights);
        $display("%0d weights saturated, %0d flagged degenerate, %0d mismatches",
                 n_sat, n_degen, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
